// ===== hw/rtl/tq_pkg.sv =====
package tq_pkg;

   localparam int FUNC_W    = 2;
   localparam int MEMBER_W  = 10;
   localparam int TEAM_ID_W = 4;
   localparam int STATUS_W  = 2;

   localparam logic [FUNC_W-1:0] FUNC_MAP     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEQUEUE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Requests from the sequencer to the team order ring.
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } tq_order_ctl_type;

endpackage

// ===== hw/rtl/team_queue.sv =====
// From acceptance to rsp_valid: map FETCH, RESULT; enqueue FETCH, TEAM, RESULT; dequeue
// FETCH, TEAM, SLOT, RESULT (FETCH, RESULT if no team waits); clear FETCH, SWEEP, RESULT.
// One transaction is in flight at a time; the next request is taken in the cycle after the
// result is registered, and RESULT waits while rsp_stall holds the output. The steps follow
// the registered reads of the team order ring, the team state memory and the member store.
// Synchronous reset, then req_stall is held while the sweep zeroes the map and team state.
module team_queue #(
   parameter int TEAMS      = 16,
   parameter int MEMBERS    = 1024,
   parameter int TEAM_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tq_pkg::FUNC_W-1:0]    req_func,
   input  logic [tq_pkg::MEMBER_W-1:0]  req_member_id,
   input  logic [tq_pkg::TEAM_ID_W-1:0] req_team_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tq_pkg::MEMBER_W-1:0]  rsp_out_member,
   output logic [tq_pkg::STATUS_W-1:0]  rsp_status
);

   import tq_pkg::*;

   localparam int TW    = (TEAMS > 1) ? $clog2(TEAMS) : 1;
   localparam int MW    = $clog2(MEMBERS);
   localparam int PW    = (TEAM_DEPTH > 1) ? $clog2(TEAM_DEPTH) : 1;
   localparam int CW    = $clog2(TEAM_DEPTH + 1);
   localparam int OCW   = $clog2(TEAMS + 1);
   localparam int SWEEP = (MEMBERS > TEAMS) ? MEMBERS : TEAMS;
   localparam int SW    = $clog2(SWEEP);

   localparam logic [2:0] S_SWEEP  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_FETCH  = 3'd2;
   localparam logic [2:0] S_TEAM   = 3'd3;
   localparam logic [2:0] S_SLOT   = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [SW-1:0]        sweep_ff, sweep_in;
   logic                 sweep_rsp_ff, sweep_rsp_in;
   logic [FUNC_W-1:0]    func_ff;
   logic [MEMBER_W-1:0]  member_ff;
   logic [TW-1:0]        tid_ff;
   logic [TW-1:0]        team_ff, team_in;
   logic [MEMBER_W-1:0]  res_member_ff, res_member_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MEMBER_W-1:0]  rsp_member_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   logic [MEMBER_W-1:0]  mem_red;
   logic [TEAM_ID_W-1:0] tid_red;
   logic                 accept;
   logic                 rsp_free;

   logic [TW-1:0]        map_rd_data;
   logic                 map_wr_en;
   logic [MW-1:0]        map_wr_addr;
   logic [TW-1:0]        map_wr_data;

   logic [PW-1:0]        st_rd_head;
   logic [CW-1:0]        st_rd_count;
   logic                 st_wr_en;
   logic [TW-1:0]        st_wr_addr;
   logic [PW-1:0]        st_wr_head;
   logic [CW-1:0]        st_wr_count;
   logic [MEMBER_W-1:0]  slot_rd_data;
   logic                 slot_wr_en;
   logic [PW:0]          tail_sum;
   logic [PW-1:0]        tail_pos;
   logic [PW-1:0]        head_next;
   logic [CW-1:0]        count_dec;

   tq_order_ctl_type     order_ctl;
   logic [TW-1:0]        order_head_team;
   logic                 order_empty;

   logic                 sweep_member;
   logic                 sweep_team;
   logic                 sweep_last;

   // Identifiers beyond the configured range wrap round; each step takes off one
   // shifted multiple of the modulus.
   always_comb begin
      mem_red = req_member_id;
      for (int k = MEMBER_W - 1; k >= 0; k--) begin
         if ((longint'(MEMBERS) << k) <= longint'(mem_red)) begin
            mem_red = mem_red - MEMBER_W'(longint'(MEMBERS) << k);
         end
      end
   end

   always_comb begin
      tid_red = req_team_id;
      for (int k = TEAM_ID_W - 1; k >= 0; k--) begin
         if ((longint'(TEAMS) << k) <= longint'(tid_red)) begin
            tid_red = tid_red - TEAM_ID_W'(longint'(TEAMS) << k);
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign sweep_member = ({1'b0, sweep_ff} < (SW+1)'(MEMBERS));
   assign sweep_team   = ({1'b0, sweep_ff} < (SW+1)'(TEAMS));
   assign sweep_last   = (sweep_ff == SW'(SWEEP - 1));

   // The enqueue position lies count places beyond the head, wrapped once.
   assign tail_sum  = (PW+1)'(st_rd_head) + (PW+1)'(st_rd_count);
   assign tail_pos  = (tail_sum >= (PW+1)'(TEAM_DEPTH))
                      ? PW'(tail_sum - (PW+1)'(TEAM_DEPTH)) : PW'(tail_sum);
   assign head_next = (st_rd_head == PW'(TEAM_DEPTH - 1)) ? '0 : st_rd_head + PW'(1);
   assign count_dec = (st_rd_count != '0) ? st_rd_count - CW'(1) : st_rd_count;

   always_comb begin
      map_wr_en   = 1'b0;
      map_wr_addr = MW'(member_ff);
      map_wr_data = tid_ff;
      if (state_ff == S_SWEEP) begin
         map_wr_en   = sweep_member;
         map_wr_addr = MW'(sweep_ff);
         map_wr_data = '0;
      end else if (state_ff == S_FETCH && func_ff == FUNC_MAP) begin
         map_wr_en = 1'b1;
      end
   end

   always_comb begin
      st_wr_en    = 1'b0;
      st_wr_addr  = team_ff;
      st_wr_head  = st_rd_head;
      st_wr_count = st_rd_count;
      slot_wr_en  = 1'b0;
      order_ctl   = '0;
      if (state_ff == S_SWEEP) begin
         st_wr_en        = sweep_team;
         st_wr_addr      = TW'(sweep_ff);
         st_wr_head      = '0;
         st_wr_count     = '0;
         order_ctl.clear = 1'b1;
      end else if (state_ff == S_TEAM) begin
         if (func_ff == FUNC_ENQUEUE) begin
            if (st_rd_count != CW'(TEAM_DEPTH)) begin
               st_wr_en       = 1'b1;
               st_wr_count    = st_rd_count + CW'(1);
               slot_wr_en     = 1'b1;
               order_ctl.push = (st_rd_count == '0);
            end
         end else begin
            st_wr_en      = 1'b1;
            st_wr_head    = head_next;
            st_wr_count   = count_dec;
            order_ctl.pop = (count_dec == '0);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      team_in       = team_ff;
      res_member_in = res_member_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_SWEEP: begin
            sweep_in = sweep_ff + SW'(1);
            if (sweep_last) begin
               sweep_in = '0;
               state_in = sweep_rsp_ff ? S_RESULT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            res_member_in = '0;
            res_status_in = STATUS_OK;
            team_in       = (func_ff == FUNC_ENQUEUE) ? map_rd_data : order_head_team;
            case (func_ff)
               FUNC_MAP: begin
                  state_in = S_RESULT;
               end
               FUNC_ENQUEUE: begin
                  state_in = S_TEAM;
               end
               FUNC_DEQUEUE: begin
                  if (order_empty) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = S_RESULT;
                  end else begin
                     state_in = S_TEAM;
                  end
               end
               FUNC_CLEAR: begin
                  sweep_rsp_in = 1'b1;
                  state_in     = S_SWEEP;
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end
         S_TEAM: begin
            if (func_ff == FUNC_ENQUEUE) begin
               if (st_rd_count == CW'(TEAM_DEPTH)) begin
                  res_status_in = STATUS_FULL;
               end
               state_in = S_RESULT;
            end else begin
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            res_member_in = slot_rd_data;
            state_in      = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               sweep_rsp_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A clear leaves its result zero; the sweep that follows it reports status ok.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         member_ff <= mem_red;
         tid_ff    <= TW'(tid_red);
      end
      team_ff       <= team_in;
      res_member_ff <= res_member_in;
      res_status_ff <= res_status_in;
      if (state_ff == S_RESULT && rsp_free) begin
         rsp_member_ff <= res_member_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   tq_map_mem #(
      .MEMBERS (MEMBERS),
      .MW      (MW),
      .TW      (TW)
   ) u_map_mem (
      .clock   (clock),
      .rd_addr (MW'(mem_red)),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data)
   );

   tq_team_store #(
      .TEAMS      (TEAMS),
      .TEAM_DEPTH (TEAM_DEPTH),
      .TW         (TW),
      .PW         (PW),
      .CW         (CW)
   ) u_team_store (
      .clock        (clock),
      .st_rd_addr   (team_in),
      .st_rd_head   (st_rd_head),
      .st_rd_count  (st_rd_count),
      .st_wr_en     (st_wr_en),
      .st_wr_addr   (st_wr_addr),
      .st_wr_head   (st_wr_head),
      .st_wr_count  (st_wr_count),
      .slot_rd_team (team_ff),
      .slot_rd_pos  (st_rd_head),
      .slot_rd_data (slot_rd_data),
      .slot_wr_en   (slot_wr_en),
      .slot_wr_team (team_ff),
      .slot_wr_pos  (tail_pos),
      .slot_wr_data (member_ff)
   );

   tq_order #(
      .TEAMS (TEAMS),
      .TW    (TW),
      .OCW   (OCW)
   ) u_order (
      .clock     (clock),
      .reset     (reset),
      .ctl       (order_ctl),
      .push_team (team_ff),
      .head_team (order_head_team),
      .empty     (order_empty)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_member = rsp_member_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== hw/rtl/tq_map_mem.sv =====
module tq_map_mem #(
   parameter int MEMBERS = 1024,
   parameter int MW      = 10,
   parameter int TW      = 4
) (
   input  logic          clock,
   input  logic [MW-1:0] rd_addr,
   output logic [TW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [MW-1:0] wr_addr,
   input  logic [TW-1:0] wr_data
);

   logic [TW-1:0] member_team_mem [MEMBERS];
   logic [TW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         member_team_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= member_team_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tq_team_store.sv =====
module tq_team_store #(
   parameter int TEAMS      = 16,
   parameter int TEAM_DEPTH = 64,
   parameter int TW         = 4,
   parameter int PW         = 6,
   parameter int CW         = 7
) (
   input  logic                        clock,
   // Per-team read position and fill count.
   input  logic [TW-1:0]               st_rd_addr,
   output logic [PW-1:0]               st_rd_head,
   output logic [CW-1:0]               st_rd_count,
   input  logic                        st_wr_en,
   input  logic [TW-1:0]               st_wr_addr,
   input  logic [PW-1:0]               st_wr_head,
   input  logic [CW-1:0]               st_wr_count,
   // Waiting members, one circular store per team.
   input  logic [TW-1:0]               slot_rd_team,
   input  logic [PW-1:0]               slot_rd_pos,
   output logic [tq_pkg::MEMBER_W-1:0] slot_rd_data,
   input  logic                        slot_wr_en,
   input  logic [TW-1:0]               slot_wr_team,
   input  logic [PW-1:0]               slot_wr_pos,
   input  logic [tq_pkg::MEMBER_W-1:0] slot_wr_data
);

   import tq_pkg::*;

   logic [PW+CW-1:0]    state_mem [TEAMS];
   logic [MEMBER_W-1:0] slot_mem  [TEAMS][TEAM_DEPTH];

   logic [PW+CW-1:0]    st_rd_ff;
   logic [MEMBER_W-1:0] slot_rd_ff;

   always_ff @(posedge clock) begin
      if (st_wr_en) begin
         state_mem[st_wr_addr] <= {st_wr_head, st_wr_count};
      end
      st_rd_ff <= state_mem[st_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem[slot_wr_team][slot_wr_pos] <= slot_wr_data;
      end
      slot_rd_ff <= slot_mem[slot_rd_team][slot_rd_pos];
   end

   assign st_rd_head   = st_rd_ff[PW+CW-1:CW];
   assign st_rd_count  = st_rd_ff[CW-1:0];
   assign slot_rd_data = slot_rd_ff;

endmodule

// ===== hw/rtl/tq_order.sv =====
module tq_order #(
   parameter int TEAMS = 16,
   parameter int TW    = 4,
   parameter int OCW   = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tq_pkg::tq_order_ctl_type ctl,
   input  logic [TW-1:0]            push_team,
   output logic [TW-1:0]            head_team,
   output logic                     empty
);

   logic [TW-1:0]  ring_mem [TEAMS];
   logic [TW-1:0]  head_team_ff;
   logic [TW-1:0]  head_ff, head_in;
   logic [OCW-1:0] count_ff, count_in;
   logic [OCW:0]   tail_sum;
   logic [TW-1:0]  tail;

   // A team is only pushed while absent, so the count is below TEAMS and
   // one conditional subtraction wraps the tail.
   assign tail_sum = (OCW+1)'(head_ff) + (OCW+1)'(count_ff);
   assign tail     = (tail_sum >= (OCW+1)'(TEAMS)) ? TW'(tail_sum - (OCW+1)'(TEAMS))
                                                   : TW'(tail_sum);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + OCW'(1);
      end else if (ctl.pop) begin
         head_in  = (head_ff == TW'(TEAMS - 1)) ? '0 : head_ff + TW'(1);
         count_in = count_ff - OCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.clear) begin
         ring_mem[tail] <= push_team;
      end
      head_team_ff <= ring_mem[head_ff];
   end

   assign head_team = head_team_ff;
   assign empty     = (count_ff == '0);

endmodule

// ===== dv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tq_pkg::*;

   localparam int TEAMS      = 16;
   localparam int MEMBERS    = 1024;
   localparam int TEAM_DEPTH = 64;
   localparam int RANDOM_ITEMS = 1250;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [MEMBER_W-1:0] member;
      logic [STATUS_W-1:0] status;
   } tq_result_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [MEMBER_W-1:0]  member;
      logic [TEAM_ID_W-1:0] team;
      logic [7:0]           reps;
      bit                   typed;
      tq_result_type        outcome;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func = FUNC_MAP;
   logic [MEMBER_W-1:0]  req_member_id = '0;
   logic [TEAM_ID_W-1:0] req_team_id = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [MEMBER_W-1:0]  rsp_out_member;
   logic [STATUS_W-1:0]  rsp_status;

   // Shadow of the queue contents: team map, per-team waiting lines and the team order.
   logic [TEAM_ID_W-1:0] team_of_member [MEMBERS] = '{default: '0};
   logic [MEMBER_W-1:0]  waiting_members [TEAMS][$];
   logic [TEAM_ID_W-1:0] team_order [$];
   tq_result_type        expected_results [$];

   int mismatches = 0;
   int items_sent = 0;
   bit idle_on = 1'b1;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   directed_row_type directed_plan [0:20] = '{
      '{FUNC_DEQUEUE, 10'd0,    4'd0,  8'd1,  1'b1, '{10'd0, STATUS_EMPTY}},
      '{FUNC_ENQUEUE, 10'd1023, 4'd15, 8'd1,  1'b1, '{10'd0, STATUS_OK}},
      '{FUNC_MAP,     10'd1023, 4'd15, 8'd1,  1'b1, '{10'd0, STATUS_OK}},
      '{FUNC_ENQUEUE, 10'd1023, 4'd0,  8'd1,  1'b0, '{10'd0, STATUS_OK}},
      '{FUNC_MAP,     10'd5,    4'd15, 8'd1,  1'b1, '{10'd0, STATUS_OK}},
      '{FUNC_ENQUEUE, 10'd5,    4'd0,  8'd1,  1'b0, '{10'd0, STATUS_OK}},
      '{FUNC_ENQUEUE, 10'd0,    4'd0,  8'd1,  1'b0, '{10'd0, STATUS_OK}},
      '{FUNC_DEQUEUE, 10'd0,    4'd0,  8'd4,  1'b0, '{10'd0, STATUS_OK}},
      '{FUNC_DEQUEUE, 10'd1023, 4'd15, 8'd1,  1'b1, '{10'd0, STATUS_EMPTY}},
      '{FUNC_MAP,     10'd682,  4'd10, 8'd1,  1'b1, '{10'd0, STATUS_OK}},
      '{FUNC_MAP,     10'd341,  4'd5,  8'd1,  1'b1, '{10'd0, STATUS_OK}},
      '{FUNC_ENQUEUE, 10'd682,  4'd0,  8'd64, 1'b0, '{10'd0, STATUS_OK}},
      '{FUNC_ENQUEUE, 10'd682,  4'd0,  8'd1,  1'b1, '{10'd0, STATUS_FULL}},
      '{FUNC_ENQUEUE, 10'd341,  4'd0,  8'd1,  1'b0, '{10'd0, STATUS_OK}},
      // Remapping a member that is still waiting only affects later enqueues.
      '{FUNC_MAP,     10'd682,  4'd5,  8'd1,  1'b0, '{10'd0, STATUS_OK}},
      '{FUNC_ENQUEUE, 10'd682,  4'd0,  8'd1,  1'b0, '{10'd0, STATUS_OK}},
      '{FUNC_DEQUEUE, 10'd0,    4'd0,  8'd3,  1'b0, '{10'd0, STATUS_OK}},
      '{FUNC_CLEAR,   10'd1023, 4'd15, 8'd1,  1'b1, '{10'd0, STATUS_OK}},
      '{FUNC_DEQUEUE, 10'd0,    4'd0,  8'd1,  1'b1, '{10'd0, STATUS_EMPTY}},
      '{FUNC_ENQUEUE, 10'd682,  4'd0,  8'd1,  1'b0, '{10'd0, STATUS_OK}},
      '{FUNC_DEQUEUE, 10'd0,    4'd0,  8'd1,  1'b0, '{10'd0, STATUS_OK}}
   };

   team_queue #(
      .TEAMS      (TEAMS),
      .MEMBERS    (MEMBERS),
      .TEAM_DEPTH (TEAM_DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_member_id  (req_member_id),
      .req_team_id    (req_team_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_member (rsp_out_member),
      .rsp_status     (rsp_status)
   );

   always #1 clock = ~clock;

   function automatic tq_result_type predict_team_queue(input logic [FUNC_W-1:0] func,
                                                        input logic [MEMBER_W-1:0] member,
                                                        input logic [TEAM_ID_W-1:0] team);
      tq_result_type res;
      logic [TEAM_ID_W-1:0] t;
      res = '{member: '0, status: STATUS_OK};
      case (func)
         FUNC_MAP: begin
            team_of_member[member] = team;
         end
         FUNC_ENQUEUE: begin
            t = team_of_member[member];
            if (waiting_members[t].size() >= TEAM_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               if (waiting_members[t].size() == 0) team_order = {team_order, t};
               waiting_members[t] = {waiting_members[t], member};
            end
         end
         FUNC_DEQUEUE: begin
            if (team_order.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               t = team_order[0];
               res.member = waiting_members[t].pop_front();
               if (waiting_members[t].size() == 0) void'(team_order.pop_front());
            end
         end
         default: begin
            foreach (team_of_member[i]) team_of_member[i] = '0;
            foreach (waiting_members[i]) waiting_members[i].delete();
            team_order.delete();
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Offers one request, waits for it to be taken and records what must come back.
   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic [MEMBER_W-1:0] member,
                               input logic [TEAM_ID_W-1:0] team,
                               input bit typed = 1'b0,
                               input tq_result_type typed_result = '0);
      tq_result_type predicted;
      if (idle_on) begin
         while ($urandom_range(99) < 21) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_member_id <= member;
      req_team_id   <= team;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predicted = predict_team_queue(func, member, team);
      expected_results = {expected_results, (typed ? typed_result : predicted)};
      items_sent++;
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   function automatic logic [MEMBER_W-1:0] pick_member();
      if ($urandom_range(3) == 0) return MEMBER_W'($urandom_range(MEMBERS - 1));
      return MEMBER_W'($urandom_range(23));
   endfunction

   function automatic logic [TEAM_ID_W-1:0] pick_team();
      return TEAM_ID_W'($urandom_range(TEAMS - 1));
   endfunction

   task automatic drain_all();
      while (team_order.size() != 0) send_request(FUNC_DEQUEUE, pick_member(), pick_team());
      send_request(FUNC_DEQUEUE, pick_member(), pick_team());
   endtask

   // Receiver: random back-pressure, plus long hold-offs on request from the stimulus.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 21);
      end
   end

   always @(posedge clock) begin
      tq_result_type awaited;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: member %0d status %0d",
                                      rsp_out_member, rsp_status));
         end else begin
            awaited = expected_results.pop_front();
            if (rsp_out_member !== awaited.member)
               report_mismatch($sformatf("out_member %0d, expected %0d",
                                         rsp_out_member, awaited.member));
            if (rsp_status !== awaited.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, awaited.status));
         end
      end
   end

   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int kind;
      int reps;
      int crew_size;
      int start;
      int r;
      bit second_hold_done;
      logic [TEAM_ID_W-1:0] t;
      logic [MEMBER_W-1:0] crew [8];
      logic [FUNC_W-1:0] f;

      second_hold_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         repeat (directed_plan[i].reps)
            send_request(directed_plan[i].func, directed_plan[i].member, directed_plan[i].team,
                         directed_plan[i].typed, directed_plan[i].outcome);
      end

      pause_until_drained();
      start = items_sent;
      // The block holds one transaction at a time, so a long receiver hold-off backs up
      // the request side almost at once.
      hold_requests++;
      repeat (12) send_request(FUNC_ENQUEUE, pick_member(), pick_team());

      while (items_sent < start + RANDOM_ITEMS) begin
         idle_on = !(items_sent - start >= 500 && items_sent - start < 800);
         if (!second_hold_done && items_sent - start >= 1000) begin
            second_hold_done = 1'b1;
            hold_requests++;
         end
         kind = $urandom_range(99);
         if (kind < 45) begin
            reps = $urandom_range(20, 60);
            repeat (reps) begin
               r = $urandom_range(99);
               f = r < 20 ? FUNC_MAP : r < 62 ? FUNC_ENQUEUE : r < 99 ? FUNC_DEQUEUE : FUNC_CLEAR;
               send_request(f, pick_member(), pick_team());
            end
         end else if (kind < 65) begin
            // Fill one team, at times beyond its depth, then dequeue part of what is waiting.
            t = pick_team();
            crew_size = $urandom_range(1, 6);
            for (int i = 0; i < crew_size; i++) begin
               crew[i] = pick_member();
               send_request(FUNC_MAP, crew[i], t);
            end
            reps = $urandom_range(10, 70);
            repeat (reps)
               send_request(FUNC_ENQUEUE, crew[$urandom_range(crew_size - 1)], pick_team());
            reps = $urandom_range(5, 40);
            repeat (reps) send_request(FUNC_DEQUEUE, pick_member(), pick_team());
         end else if (kind < 85) begin
            crew_size = $urandom_range(2, 8);
            for (int i = 0; i < crew_size; i++) begin
               crew[i] = pick_member();
               send_request(FUNC_MAP, crew[i], pick_team());
            end
            reps = $urandom_range(10, 30);
            repeat (reps)
               send_request(FUNC_ENQUEUE, crew[$urandom_range(crew_size - 1)], pick_team());
            if ($urandom_range(1) == 0) pause_until_drained();
            drain_all();
         end else begin
            reps = $urandom_range(1, 4);
            repeat (reps)
               send_request(FUNC_W'($urandom_range(3)), MEMBER_W'($urandom_range(MEMBERS - 1)),
                            pick_team());
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
